FILE: src/afma_pkg.sv
// types, constants and codes shared by the angular flux moment accumulator
// no dependencies, compiled first

package afma_pkg;

   localparam int DIMENSIONS_DEFAULT = 3;

   localparam int IDX_W      = 2;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int A_W    = 37;
   localparam int B_W    = 33;
   localparam int P_W    = A_W + B_W;
   localparam int WF_W   = 37;
   localparam int DOT_W  = 34;
   localparam int LEN_W  = 32;
   localparam int RDOT_W = 20;
   localparam int L_W    = 18;
   localparam int C_W    = 32;
   localparam int TERM_W = 50;
   localparam int ACC_W  = 48;
   localparam int SUM_W  = TERM_W + 1;

   localparam logic [2:0] REG_MODE     = 3'd0;
   localparam logic [2:0] REG_NORMAL_X = 3'd1;
   localparam logic [2:0] REG_NORMAL_Y = 3'd2;
   localparam logic [2:0] REG_NORMAL_Z = 3'd3;
   localparam logic [2:0] REG_INV_XS   = 3'd4;

   localparam logic [1:0] MODE_NET     = 2'd0;
   localparam logic [1:0] MODE_DIR_CUR = 2'd1;
   localparam logic [1:0] MODE_DIR_FLX = 2'd2;
   localparam logic [1:0] MODE_EDD     = 2'd3;

   localparam logic signed [P_W-1:0] HALF12 = P_W'(2048);
   localparam logic signed [P_W-1:0] HALF14 = P_W'(8192);
   localparam logic signed [P_W-1:0] HALF16 = P_W'(32768);
   localparam logic signed [P_W-1:0] HALF26 = P_W'(33554432);

   localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'(64'sd140737488355327);
   localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

   typedef struct packed {
      logic        [15:0] weight;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [31:0] flux_value;
      logic signed [31:0] grad_x;
      logic signed [31:0] grad_y;
      logic signed [31:0] grad_z;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic signed [47:0] sum_x;
      logic signed [47:0] sum_y;
      logic signed [47:0] sum_z;
      logic               overflowed;
   } rsp_type;

   typedef struct packed {
      logic        [1:0]  moment_mode;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic        [23:0] inv_total_xs;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_WF,
      OP_DOT,
      OP_LEN,
      OP_RDOT,
      OP_FLUX,
      OP_WL,
      OP_C,
      OP_NET,
      OP_EDD
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WF,
      ST_VEC,
      ST_WAIT,
      ST_SCALE,
      ST_CHAIN,
      ST_CWAIT,
      ST_TERM,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] idx;
      logic             rsp_load;
      logic             acc_clear;
   } seq_ctrl_type;

endpackage

FILE: src/afma_csr.sv
// apb register file: moment mode, surface normal, reciprocal cross section
// depends on afma_pkg

module afma_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [afma_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [afma_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [afma_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output afma_pkg::cfg_type                cfg
);
   import afma_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MODE:     cfg_in.moment_mode  = pwdata[1:0];
            REG_NORMAL_X: cfg_in.normal_x     = pwdata[15:0];
            REG_NORMAL_Y: cfg_in.normal_y     = pwdata[15:0];
            REG_NORMAL_Z: cfg_in.normal_z     = pwdata[15:0];
            REG_INV_XS:   cfg_in.inv_total_xs = pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MODE:     prdata = {30'd0, cfg_ff.moment_mode};
         REG_NORMAL_X: prdata = {16'd0, cfg_ff.normal_x};
         REG_NORMAL_Y: prdata = {16'd0, cfg_ff.normal_y};
         REG_NORMAL_Z: prdata = {16'd0, cfg_ff.normal_z};
         REG_INV_XS:   prdata = {8'd0, cfg_ff.inv_total_xs};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.moment_mode  <= MODE_NET;
         cfg_ff.normal_x     <= 16'sd16384;
         cfg_ff.normal_y     <= 16'sd0;
         cfg_ff.normal_z     <= 16'sd0;
         cfg_ff.inv_total_xs <= 24'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: src/afma_mul.sv
// shared signed multiplier with registered product
// depends on afma_pkg

module afma_mul (
   input  logic                               clock,
   input  logic signed [afma_pkg::A_W-1:0]    mul_a,
   input  logic signed [afma_pkg::B_W-1:0]    mul_b,
   output logic signed [afma_pkg::P_W-1:0]    prod
);
   import afma_pkg::*;

   logic signed [P_W-1:0] prod_ff;
   logic signed [P_W-1:0] prod_in;

   assign prod_in = P_W'(mul_a) * P_W'(mul_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: src/afma_seq.sv
// sequencer: issues at most one multiplier operation per cycle for each quadrature point
// depends on afma_pkg

module afma_seq #(
   parameter int DIMENSIONS = afma_pkg::DIMENSIONS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             mode,
   input  logic                   last_point,
   input  logic                   rsp_free,
   output logic                   req_ready,
   output afma_pkg::seq_ctrl_type ctrl
);
   import afma_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             idx_last;

   assign idx_last = (idx_ff == IDX_W'(DIMENSIONS - 1));

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      req_ready      = 1'b0;
      ctrl.op        = OP_NONE;
      ctrl.idx       = '0;
      ctrl.rsp_load  = 1'b0;
      ctrl.acc_clear = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (start) begin
               state_in = ST_WF;
            end
         end
         ST_WF: begin
            ctrl.op = OP_WF;
            idx_in  = '0;
            state_in = (mode == MODE_NET) ? ST_WAIT : ST_VEC;
         end
         ST_VEC: begin
            ctrl.op  = (mode == MODE_EDD) ? OP_LEN : OP_DOT;
            ctrl.idx = idx_ff;
            if (idx_last) begin
               state_in = ST_WAIT;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_WAIT: begin
            idx_in   = '0;
            state_in = (mode == MODE_NET) ? ST_TERM : ST_SCALE;
         end
         ST_SCALE: begin
            case (mode)
               MODE_DIR_CUR: ctrl.op = OP_RDOT;
               MODE_DIR_FLX: ctrl.op = OP_FLUX;
               MODE_EDD:     ctrl.op = OP_WL;
               default:      ctrl.op = OP_NONE;
            endcase
            state_in = (mode == MODE_EDD) ? ST_CHAIN : ST_DRAIN;
         end
         ST_CHAIN: begin
            ctrl.op  = OP_C;
            state_in = ST_CWAIT;
         end
         ST_CWAIT: begin
            idx_in   = '0;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            ctrl.op  = (mode == MODE_NET) ? OP_NET : OP_EDD;
            ctrl.idx = idx_ff;
            if (idx_last) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!last_point) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               ctrl.rsp_load  = 1'b1;
               ctrl.acc_clear = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

FILE: src/afma_datapath.sv
// operand selection, shared multiplier, rounding and saturating accumulators
// depends on afma_pkg and afma_mul

module afma_datapath #(
   parameter int DIMENSIONS = afma_pkg::DIMENSIONS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  afma_pkg::cfg_type      cfg,
   input  afma_pkg::req_type      item,
   input  afma_pkg::seq_ctrl_type ctrl,
   output afma_pkg::rsp_type      acc_sum
);
   import afma_pkg::*;

   logic signed [A_W-1:0]    mul_a;
   logic signed [B_W-1:0]    mul_b;
   logic signed [P_W-1:0]    prod;

   op_type                   op_ff;
   logic [IDX_W-1:0]         idx_ff;

   logic signed [WF_W-1:0]   wf_ff;
   logic signed [WF_W-1:0]   wf_in;
   logic signed [DOT_W-1:0]  dot_ff;
   logic signed [DOT_W-1:0]  dot_in;
   logic [LEN_W-1:0]         len2_ff;
   logic [LEN_W-1:0]         len2_in;
   logic [C_W-1:0]           c_ff;
   logic [C_W-1:0]           c_in;

   logic signed [ACC_W-1:0]  acc_ff [3];
   logic                     sat_ff;

   logic signed [15:0]       dir_sel;
   logic signed [15:0]       nrm_sel;
   logic signed [31:0]       grad_sel;
   logic signed [DOT_W-1:0]  dot_rnd;
   logic [LEN_W-1:0]         len_rnd;
   logic signed [P_W-1:0]    r12;
   logic signed [P_W-1:0]    r14;
   logic signed [P_W-1:0]    r16;
   logic signed [P_W-1:0]    r26;

   logic                     add_en;
   logic signed [TERM_W-1:0] term;
   logic signed [ACC_W-1:0]  acc_cur;
   logic signed [SUM_W-1:0]  sum;
   logic signed [ACC_W-1:0]  acc_new;
   logic                     sat_hit;

   always_comb begin
      case (ctrl.idx)
         2'd1: begin
            dir_sel  = item.dir_y;
            nrm_sel  = cfg.normal_y;
            grad_sel = item.grad_y;
         end
         2'd2: begin
            dir_sel  = item.dir_z;
            nrm_sel  = cfg.normal_z;
            grad_sel = item.grad_z;
         end
         default: begin
            dir_sel  = item.dir_x;
            nrm_sel  = cfg.normal_x;
            grad_sel = item.grad_x;
         end
      endcase
   end

   assign dot_rnd = dot_ff + DOT_W'(8192);
   assign len_rnd = len2_ff + LEN_W'(8192);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.op)
         OP_WF: begin
            mul_a = {{(A_W-16){1'b0}}, item.weight};
            mul_b = {{(B_W-32){item.flux_value[31]}}, item.flux_value};
         end
         OP_DOT: begin
            mul_a = {{(A_W-16){dir_sel[15]}}, dir_sel};
            mul_b = {{(B_W-16){nrm_sel[15]}}, nrm_sel};
         end
         OP_LEN: begin
            mul_a = {{(A_W-16){dir_sel[15]}}, dir_sel};
            mul_b = {{(B_W-16){dir_sel[15]}}, dir_sel};
         end
         OP_RDOT: begin
            mul_a = wf_ff;
            mul_b = {{(B_W-RDOT_W){dot_rnd[DOT_W-1]}}, dot_rnd[14 +: RDOT_W]};
         end
         OP_WL: begin
            mul_a = {{(A_W-16){1'b0}}, item.weight};
            mul_b = {{(B_W-L_W){1'b0}}, len_rnd[14 +: L_W]};
         end
         OP_C: begin
            mul_a = prod[A_W-1:0];
            mul_b = {{(B_W-24){1'b0}}, cfg.inv_total_xs};
         end
         OP_NET: begin
            mul_a = wf_ff;
            mul_b = {{(B_W-16){dir_sel[15]}}, dir_sel};
         end
         OP_EDD: begin
            mul_a = {{(A_W-C_W){1'b0}}, c_ff};
            mul_b = {{(B_W-32){grad_sel[31]}}, grad_sel};
         end
         default: begin
         end
      endcase
   end

   afma_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign r12 = prod + HALF12;
   assign r14 = prod + HALF14;
   assign r16 = prod + HALF16;
   assign r26 = prod + HALF26;

   always_comb begin
      wf_in   = wf_ff;
      dot_in  = dot_ff;
      len2_in = len2_ff;
      c_in    = c_ff;
      add_en  = 1'b0;
      term    = '0;
      case (op_ff)
         OP_WF: wf_in = r12[12 +: WF_W];
         OP_DOT: begin
            if (idx_ff == '0) begin
               dot_in = {{(DOT_W-32){prod[31]}}, prod[31:0]};
            end else begin
               dot_in = dot_ff + {{(DOT_W-32){prod[31]}}, prod[31:0]};
            end
         end
         OP_LEN: begin
            if (idx_ff == '0) begin
               len2_in = prod[LEN_W-1:0];
            end else begin
               len2_in = len2_ff + prod[LEN_W-1:0];
            end
         end
         OP_RDOT: begin
            add_en = !dot_ff[DOT_W-1];
            term   = r14[14 +: TERM_W];
         end
         OP_FLUX: begin
            add_en = !dot_ff[DOT_W-1];
            term   = {{(TERM_W-WF_W){wf_ff[WF_W-1]}}, wf_ff};
         end
         OP_C: c_in = r26[26 +: C_W];
         OP_NET: begin
            add_en = 1'b1;
            term   = r14[14 +: TERM_W];
         end
         OP_EDD: begin
            add_en = 1'b1;
            term   = r16[16 +: TERM_W];
         end
         default: begin
         end
      endcase
   end

   assign acc_cur = acc_ff[idx_ff];
   assign sum     = {{(SUM_W-ACC_W){acc_cur[ACC_W-1]}}, acc_cur} +
                    {term[TERM_W-1], term};

   always_comb begin
      sat_hit = 1'b0;
      acc_new = sum[ACC_W-1:0];
      if (sum > ACC_MAX) begin
         acc_new = ACC_MAX[ACC_W-1:0];
         sat_hit = 1'b1;
      end else if (sum < ACC_MIN) begin
         acc_new = ACC_MIN[ACC_W-1:0];
         sat_hit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff  <= OP_NONE;
         idx_ff <= '0;
      end else begin
         op_ff  <= ctrl.op;
         idx_ff <= ctrl.idx;
      end
   end

   always_ff @(posedge clock) begin
      wf_ff   <= wf_in;
      dot_ff  <= dot_in;
      len2_ff <= len2_in;
      c_ff    <= c_in;
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.acc_clear) begin
         acc_ff[0] <= '0;
         acc_ff[1] <= '0;
         acc_ff[2] <= '0;
         sat_ff    <= 1'b0;
      end else if (add_en) begin
         acc_ff[idx_ff] <= acc_new;
         sat_ff         <= sat_ff | sat_hit;
      end
   end

   assign acc_sum.sum_x      = acc_ff[0];
   assign acc_sum.sum_y      = acc_ff[1];
   assign acc_sum.sum_z      = acc_ff[2];
   assign acc_sum.overflowed = sat_ff;

   // accumulators and flag are empty right after a result is taken
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctrl.acc_clear |=> (acc_ff[0] == '0 && acc_ff[1] == '0 &&
                          acc_ff[2] == '0 && !sat_ff))
      else $error("accumulators not cleared after result");

   // vector terms only land in components that exist
   a_term_in_range: assert property (@(posedge clock) disable iff (reset)
      (op_ff == OP_NET || op_ff == OP_EDD) |-> (idx_ff < IDX_W'(DIMENSIONS)))
      else $error("vector term beyond configured dimensions");

   // a clear never coincides with a term being added
   a_no_add_on_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl.acc_clear |-> !add_en)
      else $error("term dropped by accumulator clear");

endmodule

FILE: src/angular_flux_moment_accumulator_top.sv
// angular flux moment accumulator: one quadrature point per transaction
// one shared multiplier serves all modes
// next point taken once the sequencer is back in idle; a last point waits on an unread result
// result shown when the last point ends
// synchronous reset clears sequencer, accumulators, result valid and registers to defaults
// depends on afma_pkg, afma_csr, afma_seq, afma_datapath, afma_mul

module angular_flux_moment_accumulator_top #(
   parameter int DIMENSIONS = afma_pkg::DIMENSIONS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  afma_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output afma_pkg::rsp_type                rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [afma_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [afma_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [afma_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import afma_pkg::*;

   cfg_type      cfg;
   seq_ctrl_type ctrl;
   rsp_type      acc_sum;
   req_type      item_ff;
   rsp_type      rsp_ff;
   rsp_type      rsp_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         rsp_free;
   logic         start;
   logic         scalar;

   assign start    = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   afma_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   afma_seq #(
      .DIMENSIONS (DIMENSIONS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .mode       (cfg.moment_mode),
      .last_point (item_ff.last_point),
      .rsp_free   (rsp_free),
      .req_ready  (req_ready),
      .ctrl       (ctrl)
   );

   afma_datapath #(
      .DIMENSIONS (DIMENSIONS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (item_ff),
      .ctrl    (ctrl),
      .acc_sum (acc_sum)
   );

   assign scalar = (cfg.moment_mode == MODE_DIR_CUR) || (cfg.moment_mode == MODE_DIR_FLX);

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctrl.rsp_load) begin
         rsp_in.sum_x      = acc_sum.sum_x;
         rsp_in.sum_y      = scalar ? '0 : acc_sum.sum_y;
         rsp_in.sum_z      = scalar ? '0 : acc_sum.sum_z;
         rsp_in.overflowed = acc_sum.overflowed;
         rsp_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         item_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // busy for the whole point once a transaction is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_ready)
      else $error("accepted a transaction while busy");

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> rsp_free)
      else $error("pending result overwritten");

endmodule

FILE: verif/tb.sv
// self-checking testbench for angular_flux_moment_accumulator_top
// streams quadrature points against a cycle-free predictor of the moment sums
// depends on afma_pkg and the accumulator rtl

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import afma_pkg::*;

   localparam int DIMS = DIMENSIONS_DEFAULT;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD = 300;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int PRESSURE_PHASE = 2;
   localparam longint ACC_TOP = 64'sd140737488355327;
   localparam longint ACC_BOTTOM = -ACC_TOP - 1;
   localparam logic [2:0] REG_SPARE = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   req_type point_q [$];
   rsp_type expected_sums [$];
   rsp_type sum_want;
   cfg_type csr_shadow;
   longint moment_acc [3];
   bit sum_saturated;
   int points_queued = 0;
   int points_taken = 0;
   int error_count = 0;

   bit gaps_on = 1'b0;
   bit stalls_on = 1'b0;
   int hold_token = 0;
   int hold_served;
   int hold_left;
   int burst_left;
   int gap_left;
   logic [3:0] slot;
   logic [15:0] ready_pattern;

   angular_flux_moment_accumulator_top #(.DIMENSIONS(DIMS)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   function automatic longint round_off(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic void add_clamped(int i, longint term);
      longint t;
      t = moment_acc[i] + term;
      if (t > ACC_TOP) begin
         t = ACC_TOP;
         sum_saturated = 1'b1;
      end
      if (t < ACC_BOTTOM) begin
         t = ACC_BOTTOM;
         sum_saturated = 1'b1;
      end
      moment_acc[i] = t;
   endfunction

   function automatic void integrate_point(req_type p);
      longint w, flux, wf, dot, len2, l, c, inv;
      longint dir [3];
      longint nrm [3];
      longint grad [3];
      bit scalar;
      rsp_type r;
      w = p.weight;
      inv = csr_shadow.inv_total_xs;
      flux = longint'($signed(p.flux_value));
      dir[0] = longint'($signed(p.dir_x));
      dir[1] = longint'($signed(p.dir_y));
      dir[2] = longint'($signed(p.dir_z));
      grad[0] = longint'($signed(p.grad_x));
      grad[1] = longint'($signed(p.grad_y));
      grad[2] = longint'($signed(p.grad_z));
      nrm[0] = longint'($signed(csr_shadow.normal_x));
      nrm[1] = longint'($signed(csr_shadow.normal_y));
      nrm[2] = longint'($signed(csr_shadow.normal_z));
      dot = 0;
      len2 = 0;
      for (int i = 0; i < DIMS; i++) begin
         dot += dir[i] * nrm[i];
         len2 += dir[i] * dir[i];
      end
      wf = round_off(w * flux, 12);
      case (csr_shadow.moment_mode)
         MODE_NET: begin
            for (int i = 0; i < DIMS; i++) add_clamped(i, round_off(wf * dir[i], 14));
         end
         MODE_DIR_CUR: begin
            if (dot >= 0) add_clamped(0, round_off(wf * round_off(dot, 14), 14));
         end
         MODE_DIR_FLX: begin
            if (dot >= 0) add_clamped(0, wf);
         end
         default: begin
            l = round_off(len2, 14);
            c = round_off(w * l * inv, 26);
            for (int i = 0; i < DIMS; i++) add_clamped(i, round_off(c * grad[i], 16));
         end
      endcase
      if (p.last_point) begin
         scalar = (csr_shadow.moment_mode == MODE_DIR_CUR) ||
                  (csr_shadow.moment_mode == MODE_DIR_FLX);
         r.sum_x = moment_acc[0][47:0];
         r.sum_y = scalar ? 48'h0 : moment_acc[1][47:0];
         r.sum_z = scalar ? 48'h0 : moment_acc[2][47:0];
         r.overflowed = sum_saturated;
         expected_sums = {expected_sums, r};
         for (int i = 0; i < 3; i++) moment_acc[i] = 0;
         sum_saturated = 1'b0;
      end
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // sender: with gaps on, bursts of random length separated by random gaps; else back to back
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (point_q.size() != 0) begin
            req_data <= point_q.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else if (gaps_on) begin
               burst_left = $urandom_range(0, 15);
               gap_left = $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random 16-bit ready patterns when stalls are on, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_served = 0;
         hold_left = 0;
         slot = '0;
         ready_pattern = '1;
      end else begin
         if (hold_token != hold_served) begin
            hold_served = hold_token;
            hold_left = LONG_HOLD;
         end
         if (slot == 4'd0) begin
            case ($urandom_range(0, 2))
               0: ready_pattern = 16'($urandom);
               1: ready_pattern = 16'($urandom | $urandom);
               default: ready_pattern = 16'($urandom & $urandom);
            endcase
            if (!stalls_on) ready_pattern = '1;
         end
         slot = slot + 4'd1;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ready_pattern[slot];
         end
      end
   end

   // result check, then prediction of the accepted point
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               report_mismatch("unexpected result sum_x", rsp_data.sum_x, 48'h0);
            end else begin
               sum_want = expected_sums.pop_front();
               if (rsp_data.sum_x !== sum_want.sum_x)
                  report_mismatch("sum_x", rsp_data.sum_x, sum_want.sum_x);
               if (rsp_data.sum_y !== sum_want.sum_y)
                  report_mismatch("sum_y", rsp_data.sum_y, sum_want.sum_y);
               if (rsp_data.sum_z !== sum_want.sum_z)
                  report_mismatch("sum_z", rsp_data.sum_z, sum_want.sum_z);
               if (rsp_data.overflowed !== sum_want.overflowed)
                  report_mismatch("overflowed", 48'(rsp_data.overflowed),
                                  48'(sum_want.overflowed));
            end
         end
         if (req_valid && req_ready) begin
            integrate_point(req_data);
            points_taken++;
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_MODE: csr_shadow.moment_mode = value[1:0];
         REG_NORMAL_X: csr_shadow.normal_x = value[15:0];
         REG_NORMAL_Y: csr_shadow.normal_y = value[15:0];
         REG_NORMAL_Z: csr_shadow.normal_z = value[15:0];
         REG_INV_XS: csr_shadow.inv_total_xs = value[23:0];
         default: ;
      endcase
   endtask

   task automatic queue_point(req_type p);
      point_q = {point_q, p};
      points_queued++;
   endtask

   // block idle: every point taken, every sum returned, pipeline drained
   task automatic settle();
      while (points_taken != points_queued || expected_sums.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic req_type point(logic [15:0] w, logic [15:0] dx, logic [15:0] dy,
                                     logic [15:0] dz, logic [31:0] f, logic [31:0] gx,
                                     logic [31:0] gy, logic [31:0] gz, bit last);
      req_type p;
      p.weight = w;
      p.dir_x = dx;
      p.dir_y = dy;
      p.dir_z = dz;
      p.flux_value = f;
      p.grad_x = gx;
      p.grad_y = gy;
      p.grad_z = gz;
      p.last_point = last;
      return p;
   endfunction

   function automatic logic [31:0] rand_field();
      int s;
      s = $urandom_range(0, 16384);
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_7FFF;
         1: return 32'h8000_8000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0;
         4, 5: return $urandom_range(0, 1) ? 32'(-s) : 32'(s);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_point(bit last);
      return point(16'(rand_field()), 16'(rand_field()), 16'(rand_field()),
                   16'(rand_field()), rand_field(), rand_field(), rand_field(),
                   rand_field(), last);
   endfunction

   initial begin
      int n;
      int len;
      logic [1:0] phase_mode;
      logic [31:0] xs;
      csr_shadow.moment_mode = MODE_NET;
      csr_shadow.normal_x = 16'sd16384;
      csr_shadow.normal_y = 16'sd0;
      csr_shadow.normal_z = 16'sd0;
      csr_shadow.inv_total_xs = 24'd65536;
      for (int i = 0; i < 3; i++) moment_acc[i] = 0;
      sum_saturated = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // net current at reset settings, field extremes
      queue_point(point(16'h0, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
      queue_point(point(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 32'h7FFF_FFFF,
                        32'h0, 32'h0, 32'h0, 1'b0));
      queue_point(point(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 32'h8000_0000,
                        32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
      queue_point(point(16'h1000, 16'h4000, 16'h0, 16'h0, 32'h0001_0000,
                        32'h0, 32'h0, 32'h0, 1'b1));
      settle();

      // directional current: positive, zero and negative dot products
      csr_write(REG_MODE, 32'(MODE_DIR_CUR));
      csr_write(REG_NORMAL_X, 32'h0000_7FFF);
      csr_write(REG_NORMAL_Y, 32'h0000_8000);
      csr_write(REG_NORMAL_Z, 32'h0);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      queue_point(point(16'h1000, 16'h4000, 16'h0, 16'h0, 32'h0003_0000,
                        32'h0, 32'h0, 32'h0, 1'b0));
      queue_point(point(16'h1000, 16'h0, 16'h0, 16'h4000, 32'h0002_0000,
                        32'h0, 32'h0, 32'h0, 1'b0));
      queue_point(point(16'h1000, 16'hC000, 16'h0, 16'h0, 32'h0005_0000,
                        32'h0, 32'h0, 32'h0, 1'b0));
      queue_point(point(16'h1000, 16'h0, 16'h4000, 16'h0, 32'h0007_0000,
                        32'h0, 32'h0, 32'h0, 1'b1));
      settle();

      // directional flux with a flipped normal
      csr_write(REG_MODE, 32'(MODE_DIR_FLX));
      csr_write(REG_NORMAL_X, 32'h0000_8000);
      csr_write(REG_NORMAL_Y, 32'h0);
      csr_write(REG_NORMAL_Z, 32'h0000_7FFF);
      queue_point(point(16'h0800, 16'h4000, 16'h0, 16'h0, 32'h0001_0000,
                        32'h0, 32'h0, 32'h0, 1'b0));
      queue_point(point(16'h0800, 16'h0, 16'h0, 16'h4000, 32'hFFFF_0000,
                        32'h0, 32'h0, 32'h0, 1'b0));
      queue_point(point(16'h0800, 16'h0, 16'h4000, 16'h0, 32'h0004_0000,
                        32'h0, 32'h0, 32'h0, 1'b1));
      settle();

      // eddington: saturate both ways, then a clean sum
      csr_write(REG_MODE, 32'(MODE_EDD));
      csr_write(REG_INV_XS, 32'h00FF_FFFF);
      repeat (3) queue_point(point(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 32'h0,
                                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
      queue_point(point(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 32'h0,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1));
      queue_point(point(16'h1000, 16'h4000, 16'h0, 16'h0, 32'h0,
                        32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 1'b1));
      settle();
      csr_write(REG_INV_XS, 32'h0);
      queue_point(point(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
      settle();

      // mode switched in the middle of an open sum
      csr_write(REG_MODE, 32'(MODE_NET));
      csr_write(REG_INV_XS, 32'h0001_0000);
      repeat (2) queue_point(point(16'h1000, 16'h4000, 16'h2000, 16'hE000, 32'h0002_0000,
                                   32'h0, 32'h0, 32'h0, 1'b0));
      settle();
      csr_write(REG_MODE, 32'(MODE_DIR_FLX));
      queue_point(point(16'h1000, 16'h0, 16'h4000, 16'h0, 32'h0001_0000,
                        32'h0, 32'h0, 32'h0, 1'b1));

      for (int k = 0; k < RANDOM_PHASES; k++) begin
         settle();
         case (k % 4)
            0: phase_mode = MODE_NET;
            1: phase_mode = MODE_DIR_CUR;
            2: phase_mode = MODE_DIR_FLX;
            default: phase_mode = MODE_EDD;
         endcase
         case ($urandom_range(0, 3))
            0: xs = 32'h00FF_FFFF;
            1: xs = 32'h0;
            2: xs = $urandom_range(0, 32'h0002_0000);
            default: xs = $urandom;
         endcase
         csr_write(REG_MODE, 32'(phase_mode));
         csr_write(REG_NORMAL_X, rand_field());
         csr_write(REG_NORMAL_Y, rand_field());
         csr_write(REG_NORMAL_Z, rand_field());
         csr_write(REG_INV_XS, xs);
         @(negedge clock);
         gaps_on = (k != 1) && ($urandom_range(0, 3) != 0);
         stalls_on = (k != 1) && ($urandom_range(0, 3) != 0);
         if (k == PRESSURE_PHASE) begin
            gaps_on = 1'b0;
            hold_token++;
         end
         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            len = (k == PRESSURE_PHASE) ? 1 : $urandom_range(1, 8);
            for (int j = 0; j < len; j++) queue_point(random_point(j == len - 1));
            n += len;
         end
      end

      settle();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
